@@ src/wtsp_pkg.sv @@
// shared types and constants for the world-to-screen projection block
// no dependencies
`timescale 1ns / 1ps
package wtsp_pkg;
    localparam int XW      = 32;  // input and output word width
    localparam int VP_W    = 14;  // viewport size width
    localparam int BOX_W   = 13;  // box register width
    localparam int QBITS   = 42;  // quotient bits, bit 41 is the cap
    localparam int AXIS_LAT = 44; // register stages through one axis divider
    localparam int CFG_IW  = 4;   // config index width
    localparam int IN_DW   = 7 * XW;
    localparam int OUT_DW  = 2 * XW;

    // config register indexes
    localparam logic [CFG_IW-1:0] CFG_VP_W   = 4'd0;
    localparam logic [CFG_IW-1:0] CFG_VP_H   = 4'd1;
    localparam logic [CFG_IW-1:0] CFG_BOX_CX = 4'd2;
    localparam logic [CFG_IW-1:0] CFG_BOX_CY = 4'd3;
    localparam logic [CFG_IW-1:0] CFG_BOX_HW = 4'd4;
    localparam logic [CFG_IW-1:0] CFG_BOX_HH = 4'd5;
    localparam logic [CFG_IW-1:0] CFG_YDOWN  = 4'd6;
    localparam logic [CFG_IW-1:0] CFG_ROWVEC = 4'd7;

    // item kinds
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROJECT = 1'b1;

    // control that travels beside the divider pipelines
    typedef struct packed {
        logic valid;
        logic behind;
    } t_ctl;
endpackage

@@ src/world_to_screen_project_box_test.sv @@
// world-to-screen projection with box test, top level
// result registered through 49 register stages after the input transaction;
// one item per cycle while the output is not stalled, set by the fully pipelined transform, dividers and output
// a stalled output freezes the whole pipeline; loads take one slot, no result
// synchronous active-low reset clears valid bits and resets config registers (viewport 1920 x 1080) only
// depends on wtsp_pkg, wtsp_xform, wtsp_axis
`timescale 1ns / 1ps
module world_to_screen_project_box_test
    import wtsp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [IN_DW-1:0]    s_axis_tdata,  // elem0, elem1, elem2, elem3, pos_x, pos_y, pos_z
    input  logic [2:0]          s_axis_tuser,  // cmd, row_index
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_DW-1:0]   m_axis_tdata,  // screen_x, screen_y
    output logic [2:0]          m_axis_tuser,  // behind, inside_box, saturated
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_IW-1:0]   i_cfg_index,
    input  logic [VP_W-1:0]     i_cfg_data
);
    localparam int CW = 66 - FRAC_BITS;
    localparam int SW = 46;
    localparam int CD = AXIS_LAT + 2;

    logic                 w_en, w_acc, w_xv;
    logic signed [CW-1:0] w_cx, w_cy, w_cw;
    logic [QBITS-1:0]     w_qx, w_qy;
    logic                 w_nx, w_ny;
    logic [VP_W-1:0]      r_vp_w, r_vp_h;
    logic [BOX_W-1:0]     r_cx, r_cy, r_hw, r_hh;
    logic                 r_ydown, r_rowvec;
    t_ctl                 r_ctl [0:CD-1];
    logic signed [SW-1:0] r_sx, r_sy, r_dx, r_dy, r_oy, r_sx2;
    logic signed [SW-1:0] w_hq, w_cxq, w_cyq, w_ty, w_adx, w_ady;
    logic signed [SW-1:0] w_max, w_min;
    logic                 r_out_valid, r_behind, r_inside, r_sat;
    logic [XW-1:0]        r_ox, r_oy2;
    logic                 w_sat_x, w_sat_y;

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_acc         = s_axis_tvalid && w_en;
    assign o_cfg_ready   = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp_w   <= VP_W'(1920);
            r_vp_h   <= VP_W'(1080);
            r_cx     <= '0;
            r_cy     <= '0;
            r_hw     <= '0;
            r_hh     <= '0;
            r_ydown  <= 1'b0;
            r_rowvec <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VP_W:   r_vp_w   <= i_cfg_data;
                CFG_VP_H:   r_vp_h   <= i_cfg_data;
                CFG_BOX_CX: r_cx     <= i_cfg_data[BOX_W-1:0];
                CFG_BOX_CY: r_cy     <= i_cfg_data[BOX_W-1:0];
                CFG_BOX_HW: r_hw     <= i_cfg_data[BOX_W-1:0];
                CFG_BOX_HH: r_hh     <= i_cfg_data[BOX_W-1:0];
                CFG_YDOWN:  r_ydown  <= i_cfg_data[0];
                CFG_ROWVEC: r_rowvec <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    wtsp_xform #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_xform (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_load     (w_acc && s_axis_tuser[0] == CMD_LOAD),
        .i_project  (w_acc && s_axis_tuser[0] == CMD_PROJECT),
        .i_row      (s_axis_tuser[2:1]),
        .i_elems    (s_axis_tdata[4*XW-1:0]),
        .i_pos      (s_axis_tdata[7*XW-1:4*XW]),
        .i_row_mode (r_rowvec),
        .o_valid    (w_xv),
        .o_cx       (w_cx),
        .o_cy       (w_cy),
        .o_cw       (w_cw)
    );

    wtsp_axis #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_axis_x (
        .i_clk (i_clk), .i_en (w_en), .i_c (w_cx), .i_w (w_cw),
        .i_dim (r_vp_w), .o_q (w_qx), .o_neg (w_nx)
    );

    wtsp_axis #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_axis_y (
        .i_clk (i_clk), .i_en (w_en), .i_c (w_cy), .i_w (w_cw),
        .i_dim (r_vp_h), .o_q (w_qy), .o_neg (w_ny)
    );

    // valid and behind beside the dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CD; k++) r_ctl[k] <= '0;
        end else if (w_en) begin
            r_ctl[0].valid  <= w_xv;
            r_ctl[0].behind <= (w_cw <= 0);
            for (int k = 1; k < CD; k++) r_ctl[k] <= r_ctl[k-1];
        end
    end

    assign w_hq  = SW'({r_vp_h, {FRAC_BITS{1'b0}}});
    assign w_cxq = SW'({r_cx, {FRAC_BITS{1'b0}}});
    assign w_cyq = SW'({r_cy, {FRAC_BITS{1'b0}}});
    assign w_ty  = w_hq - r_sy;
    assign w_adx = r_dx[SW-1] ? -r_dx : r_dx;
    assign w_ady = r_dy[SW-1] ? -r_dy : r_dy;
    assign w_max = SW'(33'sh0_7FFF_FFFF);
    assign w_min = -SW'(33'sh0_8000_0000);
    assign w_sat_x = (r_sx2 > w_max) || (r_sx2 < w_min);
    assign w_sat_y = (r_oy > w_max) || (r_oy < w_min);

    // signed results, offsets, clamp and box compare
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sx  <= w_nx ? -SW'(w_qx) : SW'(w_qx);
            r_sy  <= w_ny ? -SW'(w_qy) : SW'(w_qy);
            r_sx2 <= r_sx;
            r_dx  <= r_sx - w_cxq;
            r_dy  <= w_ty - w_cyq;
            r_oy  <= r_ydown ? w_ty : r_sy;
            r_behind <= r_ctl[CD-1].behind;
            if (r_ctl[CD-1].behind) begin
                r_ox     <= XW'(-(SW'(1) <<< FRAC_BITS));
                r_oy2    <= XW'(-(SW'(1) <<< FRAC_BITS));
                r_inside <= 1'b0;
                r_sat    <= 1'b0;
            end else begin
                r_ox     <= (r_sx2 > w_max) ? XW'(w_max) :
                            (r_sx2 < w_min) ? XW'(w_min) : XW'(r_sx2);
                r_oy2    <= (r_oy > w_max) ? XW'(w_max) :
                            (r_oy < w_min) ? XW'(w_min) : XW'(r_oy);
                r_inside <= (w_adx <= SW'({r_hw, {FRAC_BITS{1'b0}}})) &&
                            (w_ady <= SW'({r_hh, {FRAC_BITS{1'b0}}}));
                r_sat    <= w_sat_x || w_sat_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_ctl[CD-1].valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_oy2, r_ox};
    assign m_axis_tuser  = {r_sat, r_inside, r_behind};

    // a behind point never reports box hit or clamping
    a_behind_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1] && !m_axis_tuser[2])
        else $error("behind result with box or saturation flag");

    // clamping leaves a coordinate at a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |->
            m_axis_tdata[31:0] == 32'h7FFF_FFFF || m_axis_tdata[31:0] == 32'h8000_0000 ||
            m_axis_tdata[63:32] == 32'h7FFF_FFFF || m_axis_tdata[63:32] == 32'h8000_0000)
        else $error("saturated flag without clamped coordinate");

    // a stalled output freezes the input side
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while output stalled");
endmodule

@@ src/wtsp_xform.sv @@
// matrix storage and clip-space transform, two register stages
// depends on wtsp_pkg
`timescale 1ns / 1ps
module wtsp_xform
    import wtsp_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int CW = 66 - FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_load,
    input  logic                 i_project,
    input  logic [1:0]           i_row,
    input  logic [4*XW-1:0]      i_elems,
    input  logic [3*XW-1:0]      i_pos,
    input  logic                 i_row_mode,
    output logic                 o_valid,
    output logic signed [CW-1:0] o_cx,
    output logic signed [CW-1:0] o_cy,
    output logic signed [CW-1:0] o_cw
);
    logic signed [XW-1:0]     r_m [4][4];
    logic signed [2*XW-1:0]   r_prod [3][3];
    logic signed [2*XW-1:0]   n_prod [3][3];
    logic signed [XW-1:0]     r_konst [3];
    logic signed [XW-1:0]     n_konst [3];
    logic                     r_v1, r_v2;
    logic signed [CW-1:0]     r_c [3];
    logic signed [CW-1:0]     n_c [3];

    // matrix row writes
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int j = 0; j < 4; j++) r_m[i_row][j] <= i_elems[j*XW +: XW];
        end
    end

    // stage 1: products for clip x, y, w
    always_comb begin
        int oi;
        for (int k = 0; k < 3; k++) begin
            oi = (k == 2) ? 3 : k;
            for (int j = 0; j < 3; j++) begin
                n_prod[k][j] = $signed(i_pos[j*XW +: XW]) *
                               (i_row_mode ? r_m[j][oi] : r_m[oi][j]);
            end
            n_konst[k] = i_row_mode ? r_m[3][oi] : r_m[oi][3];
        end
    end

    // stage 2: floor shift and sum
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_c[k] = CW'(r_prod[k][0] >>> FRAC_BITS) + CW'(r_prod[k][1] >>> FRAC_BITS)
                   + CW'(r_prod[k][2] >>> FRAC_BITS) + CW'(r_konst[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_project;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= n_prod;
            r_konst <= n_konst;
            r_c     <= n_c;
        end
    end

    assign o_valid = r_v2;
    assign o_cx    = r_c[0];
    assign o_cy    = r_c[1];
    assign o_cw    = r_c[2];
endmodule

@@ src/wtsp_axis.sv @@
// viewport mapping of one axis: (c+w)*dim/(2w), one quotient bit per stage
// depends on wtsp_pkg
`timescale 1ns / 1ps
module wtsp_axis
    import wtsp_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int CW = 66 - FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_c,
    input  logic signed [CW-1:0] i_w,
    input  logic [VP_W-1:0]      i_dim,
    output logic [QBITS-1:0]     o_q,
    output logic                 o_neg
);
    localparam int DW = CW + 1;
    localparam int WR = CW + 43;

    logic signed [DW-1:0] n_s;
    logic [DW-1:0]        r_mag;
    logic [DW-1:0]        r_d0;
    logic                 r_neg0;
    logic [WR-1:0]        r_rem [0:QBITS-1];
    logic [DW-1:0]        r_d   [0:QBITS-1];
    logic [QBITS-1:0]     r_q   [1:QBITS];
    logic                 r_ng  [0:QBITS];

    // sum, sign and magnitude, divisor
    assign n_s = DW'(i_c) + DW'(i_w);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg0 <= n_s[DW-1];
            r_mag  <= n_s[DW-1] ? DW'(-n_s) : DW'(n_s);
            r_d0   <= DW'({i_w, 1'b0});
        end
    end

    // numerator in q format, full-width product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= (WR'(r_mag) * WR'(i_dim)) << FRAC_BITS;
            r_d[0]   <= r_d0;
            r_ng[0]  <= r_neg0;
        end
    end

    // restoring division, bit QBITS-1-j in stage j
    for (genvar j = 0; j < QBITS; j++) begin : g_div
        logic [WR-1:0]    w_t;
        logic             w_ge;
        logic [QBITS-1:0] w_qin;
        assign w_t  = WR'(r_d[j]) << (QBITS - 1 - j);
        assign w_ge = r_rem[j] >= w_t;
        if (j == 0) begin : g_first
            assign w_qin = '0;
        end else begin : g_rest
            assign w_qin = r_q[j];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[j+1]  <= w_qin | (QBITS'(w_ge) << (QBITS - 1 - j));
                r_ng[j+1] <= r_ng[j];
            end
        end
        if (j < QBITS - 1) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j+1] <= w_ge ? r_rem[j] - w_t : r_rem[j];
                    r_d[j+1]   <= r_d[j];
                end
            end
        end
    end

    // top bit set means the magnitude hit the cap
    assign o_q   = r_q[QBITS][QBITS-1] ? (QBITS'(1) << (QBITS - 1)) : r_q[QBITS];
    assign o_neg = r_ng[QBITS];
endmodule
